// ===== rtl/brrf_pkg.sv =====
`default_nettype none

package brrf_pkg;

    // Number of bytes the ring store holds; a power of two.
    localparam int unsigned DEPTH = 2048;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    // Positions count modulo twice the depth so that full and empty differ.
    localparam int unsigned POS_W = ADDR_W + 1;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FILL_W = 12;
    localparam int unsigned COUNT_W = 32;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/brrf_ram.sv =====
`default_nettype none

module brrf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/byte_receive_ring_fifo.sv =====
`default_nettype none

// Receive byte FIFO with accepted and dropped byte counters.
//
// A request is presented on command and data_byte together with start, and
// is taken at a rising edge where start is high and busy is low. A push
// (command low) stores data_byte unless the store is full, in which case the
// byte is dropped and the dropped count advances. A pop (command high)
// returns the oldest held byte, or nothing when the store is empty.
//
// Every request yields exactly one result, presented for one cycle with done
// high, in the cycle after the request is taken. The byte store is a
// single-port synchronous RAM and each request uses its one port once,
// either to write the pushed byte or to read the popped one, so a new
// request may be taken in every cycle and busy stays low.
//
// The result reports the fill level and both wrapping counters as they stand
// after the request. The receiver cannot hold a result off; it must take it
// in the cycle that done is high. Reset empties the store and clears both
// counters at once; no clearing pass is needed since only written entries
// are ever read.

module byte_receive_ring_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           command,
    input  wire logic [brrf_pkg::BYTE_W-1:0]    data_byte,
    output logic                                done,
    output logic      [brrf_pkg::BYTE_W-1:0]    read_byte,
    output logic                                read_valid,
    output logic                                push_accepted,
    output logic      [brrf_pkg::FILL_W-1:0]    fill_level,
    output logic      [brrf_pkg::COUNT_W-1:0]   received_total,
    output logic      [brrf_pkg::COUNT_W-1:0]   dropped_total
);

    import brrf_pkg::*;

    logic               accept;
    logic               is_pop;
    logic [POS_W-1:0]   held;
    logic               empty;
    logic               full;
    logic               do_write;
    logic               do_read;
    logic [ADDR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic [POS_W-1:0]   wr_pos_reg;
    logic [POS_W-1:0]   wr_pos_next;
    logic [POS_W-1:0]   rd_pos_reg;
    logic [POS_W-1:0]   rd_pos_next;
    logic [COUNT_W-1:0] accepted_count_reg;
    logic [COUNT_W-1:0] accepted_count_next;
    logic [COUNT_W-1:0] overflow_count_reg;
    logic [COUNT_W-1:0] overflow_count_next;
    logic               done_reg;
    logic               read_valid_reg;
    logic               read_valid_next;
    logic               push_accepted_reg;
    logic               push_accepted_next;

    // Each request finishes its use of the store port in the cycle it is
    // taken, so the block never needs to refuse a request.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_pop = (command == CMD_POP);

    // The positions run modulo twice the depth, so their difference is the
    // number of held bytes and never exceeds the depth.
    assign held  = wr_pos_reg - rd_pos_reg;
    assign empty = (held == '0);
    assign full  = (held == POS_W'(DEPTH));

    assign do_write = accept && !is_pop && !full;
    assign do_read  = accept && is_pop && !empty;

    // One port serves both directions: a pop reads at the read position,
    // anything else addresses the write position.
    assign ram_addr = is_pop ? rd_pos_reg[ADDR_W-1:0] : wr_pos_reg[ADDR_W-1:0];

    brrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (do_write || do_read),
        .we    (do_write),
        .addr  (ram_addr),
        .wdata (data_byte),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wr_pos_next         = wr_pos_reg;
        rd_pos_next         = rd_pos_reg;
        accepted_count_next = accepted_count_reg;
        overflow_count_next = overflow_count_reg;
        read_valid_next     = 1'b0;
        push_accepted_next  = 1'b0;
        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        overflow_count_next = overflow_count_reg + 1'b1;
                    end
                    else
                    begin
                        wr_pos_next         = wr_pos_reg + 1'b1;
                        accepted_count_next = accepted_count_reg + 1'b1;
                        push_accepted_next  = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (!empty)
                    begin
                        rd_pos_next     = rd_pos_reg + 1'b1;
                        read_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    read_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg         <= '0;
            rd_pos_reg         <= '0;
            accepted_count_reg <= '0;
            overflow_count_reg <= '0;
            done_reg           <= 1'b0;
            read_valid_reg     <= 1'b0;
            push_accepted_reg  <= 1'b0;
        end
        else
        begin
            wr_pos_reg         <= wr_pos_next;
            rd_pos_reg         <= rd_pos_next;
            accepted_count_reg <= accepted_count_next;
            overflow_count_reg <= overflow_count_next;
            done_reg           <= accept;
            read_valid_reg     <= read_valid_next;
            push_accepted_reg  <= push_accepted_next;
        end
    end

    // In the result cycle the state registers already hold the values after
    // the request, and the RAM output holds the popped byte.
    assign done           = done_reg;
    assign read_valid     = read_valid_reg;
    assign push_accepted  = push_accepted_reg;
    assign read_byte      = read_valid_reg ? ram_rdata : '0;
    assign fill_level     = FILL_W'(held);
    assign received_total = accepted_count_reg;
    assign dropped_total  = overflow_count_reg;

    // The fill level can never pass the depth.
    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held <= POS_W'(DEPTH))
        else $error("held byte count exceeds the depth");

    // Every taken request gives exactly one result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request taken without a result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a request");

    // A stored push advances the received count by one and leaves the dropped count alone.
    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (received_total == $past(accepted_count_reg) + 1'b1)
                     && (dropped_total == $past(overflow_count_reg)))
        else $error("received count did not follow a stored push");

    // A pop from an empty store leaves the level alone and returns nothing.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && empty) |=> !read_valid && (held == '0))
        else $error("pop from an empty store changed the store");

    a_exclusive_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(read_valid && push_accepted))
        else $error("pop and push result flags both set");

endmodule

`default_nettype wire
